[hw/rtl/load_store_word_unit_assert.svh]
// Assertion macros shared by the load/store word unit checkers.
`ifndef LOAD_STORE_WORD_UNIT_ASSERT_SVH
`define LOAD_STORE_WORD_UNIT_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define LSW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define LSW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/lsw_pkg.sv]
// Package with the constants, codes and control types of the load/store word unit.
package lsw_pkg;

  localparam int MEM_BYTES  = 65536;
  localparam int REG_COUNT  = 16;
  localparam int BYTE_BITS  = 8;
  localparam int WORD_W     = 32;
  localparam int WORD_BYTES = WORD_W / BYTE_BITS;
  localparam int LANE_W     = $clog2(WORD_BYTES);
  localparam int MEM_ROWS   = MEM_BYTES / WORD_BYTES;
  localparam int ROW_AW     = $clog2(MEM_ROWS);
  localparam int ADDR_W     = $clog2(MEM_BYTES);
  localparam int REG_AW     = $clog2(REG_COUNT);
  localparam int HADDR_W    = 16;
  localparam int OP_W       = 2;
  localparam int SH_AW      = $clog2(WORD_W);

  localparam logic [WORD_W-1:0] ADDR_MAX = WORD_W'(MEM_BYTES - WORD_BYTES);

  typedef enum logic [OP_W-1:0] {
    OP_EXEC,
    OP_REG_WR,
    OP_MEM_WR,
    OP_REG_RD
  } lsw_op_t;

  typedef enum logic [1:0] {
    SH_LSL,
    SH_LSR,
    SH_ASR,
    SH_ROR
  } lsw_shift_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDA,
    ST_RDB,
    ST_ADDR,
    ST_MEM,
    ST_LDWB,
    ST_POST,
    ST_HWR,
    ST_HWM,
    ST_HRD,
    ST_HRDQ,
    ST_DONE
  } lsw_state_t;

  typedef struct packed {
    logic capture;
    logic rd_shift;
    logic rd_host;
    logic ld_ofs;
    logic ld_addr;
    logic mem_rd;
    logic mem_wr;
    logic mem_host;
    logic rf_wr_host;
    logic rf_wr_load;
    logic rf_wr_post;
    logic ld_host_rd;
    logic clear;
    logic ld_out;
  } lsw_cmd_t;

  typedef struct packed {
    logic fault;
    logic load;
    logic pre;
    logic clr_last;
  } lsw_sts_t;

endpackage

[hw/rtl/lsw_chan_if.sv]
// Handshake channel interfaces for the items in and out of the load/store word unit.
interface lsw_in_if import lsw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [WORD_W-1:0]   instruction;
  logic [REG_AW-1:0]   reg_index;
  logic [HADDR_W-1:0]  host_address;
  logic [WORD_W-1:0]   host_data;

  modport source (output valid, op, instruction, reg_index, host_address, host_data,
                  input ready);
  modport sink (input valid, op, instruction, reg_index, host_address, host_data,
                output ready);
endinterface

interface lsw_out_if import lsw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] read_data;
  logic [WORD_W-1:0] transfer_address;
  logic              fault;

  modport source (output valid, read_data, transfer_address, fault, input ready);
  modport sink (input valid, read_data, transfer_address, fault, output ready);
endinterface

[hw/rtl/load_store_word_unit.sv]
// Top level of the load/store word unit: controller, datapath and channel ports.
// Execute items step through RDA, RDB, ADDR and MEM, then LDWB for loads and POST when
// post-indexed (a fault ends at MEM); host writes use HWR or HWM, host reads HRD and HRDQ.
// One item at a time, paced by the one-write-port register file and byte-bank sequence; a
// new item waits until DONE has loaded the last result. Reset clears the registers and runs
// a 16384-row (MEM_BYTES / 4) memory clearing pass during which no item is taken.
module load_store_word_unit import lsw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  lsw_in_if.sink    in_ch,
  lsw_out_if.source out_ch
);

  lsw_cmd_t cmd;
  lsw_sts_t sts;

  lsw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  lsw_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_op                (in_ch.op),
    .in_instruction       (in_ch.instruction),
    .in_reg_index         (in_ch.reg_index),
    .in_host_address      (in_ch.host_address),
    .in_host_data         (in_ch.host_data),
    .out_read_data        (out_ch.read_data),
    .out_transfer_address (out_ch.transfer_address),
    .out_fault            (out_ch.fault)
  );

endmodule

[hw/rtl/lsw_ctrl.sv]
// Controller state machine sequencing register, memory and result steps per item.
module lsw_ctrl import lsw_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  input  lsw_sts_t        sts,
  output lsw_cmd_t        cmd
);

  lsw_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       done_go;

  assign done_go   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (lsw_op_t'(in_op))
            OP_EXEC:   state_nxt = ST_RDA;
            OP_REG_WR: state_nxt = ST_HWR;
            OP_MEM_WR: state_nxt = ST_HWM;
            OP_REG_RD: state_nxt = ST_HRD;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RDA:  state_nxt = ST_RDB;
      ST_RDB:  state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = ST_MEM;
      ST_MEM: begin
        if (sts.fault) begin
          state_nxt = ST_DONE;
        end else if (sts.load) begin
          state_nxt = ST_LDWB;
        end else begin
          state_nxt = sts.pre ? ST_DONE : ST_POST;
        end
      end
      ST_LDWB: state_nxt = sts.pre ? ST_DONE : ST_POST;
      ST_POST: state_nxt = ST_DONE;
      ST_HWR:  state_nxt = ST_DONE;
      ST_HWM:  state_nxt = ST_DONE;
      ST_HRD:  state_nxt = ST_HRDQ;
      ST_HRDQ: state_nxt = ST_DONE;
      ST_DONE: begin
        if (done_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_RDA: cmd.rd_shift = 1'b1;
      ST_RDB: cmd.ld_ofs = 1'b1;
      ST_ADDR: cmd.ld_addr = 1'b1;
      ST_MEM: begin
        if (!sts.fault) begin
          cmd.mem_rd = sts.load;
          cmd.mem_wr = !sts.load;
        end
      end
      ST_LDWB: cmd.rf_wr_load = 1'b1;
      ST_POST: cmd.rf_wr_post = 1'b1;
      ST_HWR:  cmd.rf_wr_host = 1'b1;
      ST_HWM: begin
        cmd.mem_wr   = 1'b1;
        cmd.mem_host = 1'b1;
      end
      ST_HRD:  cmd.rd_host = 1'b1;
      ST_HRDQ: cmd.ld_host_rd = 1'b1;
      ST_DONE: cmd.ld_out = done_go;
      default: cmd = '0;
    endcase
  end

endmodule

[hw/rtl/lsw_dpath.sv]
// Datapath with register file, offset shifter, address adder and banked byte memory.
module lsw_dpath import lsw_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  lsw_cmd_t            cmd,
  output lsw_sts_t            sts,
  input  logic [OP_W-1:0]     in_op,
  input  logic [WORD_W-1:0]   in_instruction,
  input  logic [REG_AW-1:0]   in_reg_index,
  input  logic [HADDR_W-1:0]  in_host_address,
  input  logic [WORD_W-1:0]   in_host_data,
  output logic [WORD_W-1:0]   out_read_data,
  output logic [WORD_W-1:0]   out_transfer_address,
  output logic                out_fault
);

  localparam int BIT_I = 25;
  localparam int BIT_P = 24;
  localparam int BIT_U = 23;
  localparam int BIT_L = 20;
  localparam int IMM_W = 12;

  function automatic logic [WORD_W-1:0] shift_fn(input logic [WORD_W-1:0] v,
                                                 input lsw_shift_t kind,
                                                 input logic [7:0] amt);
    logic [2*WORD_W-1:0] dbl;
    logic                big;
    logic [SH_AW-1:0]    sa;
    logic [WORD_W-1:0]   res;
    dbl = {v, v};
    big = amt >= 8'(WORD_W);
    sa  = amt[SH_AW-1:0];
    if (amt == '0) begin
      res = v;
    end else begin
      case (kind)
        SH_LSL: res = big ? '0 : v << sa;
        SH_LSR: res = big ? '0 : v >> sa;
        SH_ASR: res = big ? {WORD_W{v[WORD_W-1]}} : WORD_W'($signed(v) >>> sa);
        SH_ROR: begin
          dbl = dbl >> sa;
          res = dbl[WORD_W-1:0];
        end
        default: res = v;
      endcase
    end
    return res;
  endfunction

  // Captured item.
  logic [OP_W-1:0]    op_r;
  logic [WORD_W-1:0]  ins_r;
  logic [REG_AW-1:0]  ri_r;
  logic [HADDR_W-1:0] haddr_r;
  logic [WORD_W-1:0]  hdata_r;

  // Working values and result.
  logic [WORD_W-1:0] delta_r, base_r, rdv_r, addr_r;
  logic [WORD_W-1:0] res_rdata_r, res_taddr_r;
  logic              res_flt_r;
  logic [WORD_W-1:0] out_rdata_r, out_taddr_r;
  logic              out_flt_r;

  // Register file.
  logic [WORD_W-1:0]    rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_r;
  logic [WORD_W-1:0]    ra_q_r, rb_q_r;
  logic                 ra_v_r, rb_v_r;
  logic [WORD_W-1:0]    ra_val, rb_val;
  logic [REG_AW-1:0]    ra_addr, rb_addr;
  logic                 rf_we;
  logic [REG_AW-1:0]    rf_wa;
  logic [WORD_W-1:0]    rf_wd;

  logic [REG_AW-1:0] rd_idx, rn_idx, rm_idx, rs_idx;
  logic [7:0]        amt;
  logic [WORD_W-1:0] sh_val, ofs, delta_nxt, addr_sum, post_sum;

  // Memory side.
  logic [ROW_AW-1:0]    clr_row_r;
  logic [WORD_W-1:0]    host_addr_w;
  logic                 host_bad;
  logic [ADDR_W-1:0]    maddr;
  logic [LANE_W-1:0]    lane;
  logic [ROW_AW-1:0]    base_row;
  logic [WORD_W-1:0]    wdata;
  logic                 bank_we;
  logic [BYTE_BITS-1:0] bank_q [WORD_BYTES];
  logic [WORD_W-1:0]    ld_word;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_op;
      ins_r   <= in_instruction;
      ri_r    <= in_reg_index;
      haddr_r <= in_host_address;
      hdata_r <= in_host_data;
    end
  end

  assign rd_idx = ins_r[15:12];
  assign rn_idx = ins_r[19:16];
  assign rm_idx = ins_r[3:0];
  assign rs_idx = ins_r[11:8];

  assign ra_addr = cmd.rd_shift ? rm_idx : (cmd.rd_host ? ri_r : rn_idx);
  assign rb_addr = cmd.rd_shift ? rs_idx : rd_idx;
  assign ra_val  = ra_v_r ? ra_q_r : '0;
  assign rb_val  = rb_v_r ? rb_q_r : '0;

  always_ff @(posedge clk) begin
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    ra_q_r <= rf_mem[ra_addr];
    rb_q_r <= rf_mem[rb_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      ra_v_r   <= 1'b0;
      rb_v_r   <= 1'b0;
    end else begin
      if (rf_we) rf_vld_r[rf_wa] <= 1'b1;
      ra_v_r <= rf_vld_r[ra_addr];
      rb_v_r <= rf_vld_r[rb_addr];
    end
  end

  always_comb begin
    amt       = ins_r[4] ? rb_val[7:0] : 8'(ins_r[11:7]);
    sh_val    = shift_fn(ra_val, lsw_shift_t'(ins_r[6:5]), amt);
    ofs       = ins_r[BIT_I] ? sh_val : WORD_W'(ins_r[IMM_W-1:0]);
    delta_nxt = ins_r[BIT_U] ? ofs : ('0 - ofs);
    addr_sum  = ra_val + (ins_r[BIT_P] ? delta_r : '0);
    post_sum  = ((ins_r[BIT_L] && (rn_idx == rd_idx)) ? res_rdata_r : base_r) + delta_r;
  end

  always_comb begin
    rf_we = cmd.rf_wr_host || cmd.rf_wr_load || cmd.rf_wr_post;
    if (cmd.rf_wr_host) begin
      rf_wa = ri_r;
      rf_wd = hdata_r;
    end else if (cmd.rf_wr_load) begin
      rf_wa = rd_idx;
      rf_wd = ld_word;
    end else begin
      rf_wa = rn_idx;
      rf_wd = post_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_ofs) delta_r <= delta_nxt;
    if (cmd.ld_addr) begin
      base_r <= ra_val;
      rdv_r  <= rb_val;
      addr_r <= addr_sum;
    end
    if (cmd.capture) begin
      res_rdata_r <= '0;
      res_taddr_r <= '0;
      res_flt_r   <= 1'b0;
    end else begin
      if (cmd.ld_addr) begin
        res_taddr_r <= addr_sum;
        res_flt_r   <= addr_sum > ADDR_MAX;
      end
      if (cmd.rf_wr_load) res_rdata_r <= ld_word;
      if (cmd.ld_host_rd) res_rdata_r <= ra_val;
      if (cmd.mem_wr && cmd.mem_host) res_flt_r <= host_bad;
    end
    if (cmd.ld_out) begin
      out_rdata_r <= res_rdata_r;
      out_taddr_r <= res_taddr_r;
      out_flt_r   <= res_flt_r;
    end
  end

  // The clearing pass zeroes one row of all byte banks per cycle after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_row_r <= '0;
    end else if (cmd.clear) begin
      clr_row_r <= clr_row_r + 1'b1;
    end
  end

  assign host_addr_w = WORD_W'(haddr_r);
  assign host_bad    = host_addr_w > ADDR_MAX;
  assign maddr       = cmd.mem_host ? host_addr_w[ADDR_W-1:0] : addr_r[ADDR_W-1:0];
  assign lane        = maddr[LANE_W-1:0];
  assign base_row    = maddr[ADDR_W-1:LANE_W];
  assign wdata       = cmd.mem_host ? hdata_r : rdv_r;
  assign bank_we     = cmd.clear || (cmd.mem_wr && !(cmd.mem_host && host_bad));

  // Byte address a lives in bank a mod 4 at row a / 4; a word spans all four banks.
  for (genvar b = 0; b < WORD_BYTES; b++) begin : g_bank
    logic [BYTE_BITS-1:0] mem [MEM_ROWS];
    logic [BYTE_BITS-1:0] q_r;
    logic [ROW_AW-1:0]    row;
    logic [LANE_W-1:0]    k;
    logic [BYTE_BITS-1:0] wbyte;

    always_comb begin
      k     = LANE_W'(b) - lane;
      row   = cmd.clear ? clr_row_r : base_row + ROW_AW'(lane > LANE_W'(b));
      wbyte = cmd.clear ? '0 : wdata[k*BYTE_BITS +: BYTE_BITS];
    end

    always_ff @(posedge clk) begin
      if (bank_we) mem[row] <= wbyte;
      if (cmd.mem_rd) q_r <= mem[row];
    end

    assign bank_q[b] = q_r;
  end

  always_comb begin
    for (int j = 0; j < WORD_BYTES; j++) begin
      ld_word[j*BYTE_BITS +: BYTE_BITS] =
        bank_q[LANE_W'(addr_r[LANE_W-1:0] + LANE_W'(j))];
    end
  end

  assign sts.fault    = res_flt_r;
  assign sts.load     = ins_r[BIT_L];
  assign sts.pre      = ins_r[BIT_P] || (lsw_op_t'(op_r) != OP_EXEC);
  assign sts.clr_last = clr_row_r == ROW_AW'(MEM_ROWS - 1);

  assign out_read_data        = out_rdata_r;
  assign out_transfer_address = out_taddr_r;
  assign out_fault            = out_flt_r;

endmodule

[hw/rtl/lsw_chk.sv]
// Port-level checker for the load/store word unit and its bind to the top level.
`include "load_store_word_unit_assert.svh"

module lsw_chk import lsw_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_fault,
  input logic [WORD_W-1:0] out_read_data
);

  `LSW_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")
  `LSW_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "item taken while busy")
  `LSW_ASSERT(a_fault_no_data, out_valid && out_fault |-> out_read_data == '0, "fault with data")
  `LSW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_read_data), "result dropped")

endmodule

bind load_store_word_unit lsw_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_fault     (out_ch.fault),
  .out_read_data (out_ch.read_data)
);
